>>> hw/rtl/chrssi_pkg.sv
// ----------------------------------------------------------------------------
// chrssi_pkg
// Shared types and constants of the per-channel RSSI peak hold monitor.
// ----------------------------------------------------------------------------
package chrssi_pkg;

    // channel table geometry
    localparam int NUM_CHANNELS = 14;
    localparam int COUNT_WIDTH  = 32;
    localparam int CH_W         = 4;
    localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);

    // field widths
    localparam int FUNC_W = 3;
    localparam int RSSI_W = 8;
    localparam int PKT_W  = 32;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_CHANNEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL  = 1'b1;

    // reset and special values
    localparam logic [CH_W-1:0]          RESET_LAST_CHANNEL = 4'd13;
    localparam logic signed [RSSI_W-1:0] RESET_FLOOR        = -8'sd100;
    localparam logic signed [RSSI_W-1:0] OUT_OF_RANGE_PEAK  = -8'sd128;
    localparam logic [CH_W-1:0]          FIRST_CHANNEL      = 4'd1;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_FRAME = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_HOP   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DECAY = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

    // queue geometry, both queues
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // classified operation
    typedef enum logic [2:0] {
        OP_FRAME,
        OP_HOP,
        OP_DECAY,
        OP_CLEAR,
        OP_READ,
        OP_NONE
    } op_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HOP,
        ST_SWEEP,
        ST_REPORT
    } state_t;

    // classified request handed from front to back
    typedef struct packed {
        op_t                      op;
        logic signed [RSSI_W-1:0] rssi;
        logic [CH_W-1:0]          query;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [CH_W-1:0]          report_channel;
        logic signed [RSSI_W-1:0] peak_rssi;
        logic [PKT_W-1:0]         packet_count;
        logic [CH_W-1:0]          active_channel;
    } res_t;

endpackage

>>> hw/rtl/channel_rssi_peak_hold_monitor_core.sv
// ----------------------------------------------------------------------------
// channel_rssi_peak_hold_monitor_core
// Per-channel RSSI peak hold monitor with packet counts, hop and decay.
// ----------------------------------------------------------------------------
// Sequencing: frame, clear, read and unused codes take effect in IDLE and report from
//   REPORT; hop steps through HOP, subtracting the last channel once per wrap, then
//   reports; decay sweeps channels 1 to the last channel (up to 14) in SWEEP, then reports.
// The back end takes one request at a time and takes no new request until the result of
//   the last has been pushed; it waits in REPORT while the result queue is full.
// Reset: asynchronous, active low; peaks -100, counts 0, current channel 1,
//   last channel 13, floor -100, both queues empty; no clearing pass.
module channel_rssi_peak_hold_monitor_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [chrssi_pkg::FUNC_W-1:0]         func,
    input  logic signed [chrssi_pkg::RSSI_W-1:0]  rssi,
    input  logic [chrssi_pkg::CH_W-1:0]           query_channel,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [chrssi_pkg::CH_W-1:0]           report_channel,
    output logic signed [chrssi_pkg::RSSI_W-1:0]  peak_rssi,
    output logic [chrssi_pkg::PKT_W-1:0]          packet_count,
    output logic [chrssi_pkg::CH_W-1:0]           active_channel,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [chrssi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [chrssi_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import chrssi_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic res_push;
    res_t res;
    logic res_full;
    res_t res_out;

    // request intake and classification
    chrssi_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .func          (func),
        .rssi          (rssi),
        .query_channel (query_channel),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    // execution against the channel tables
    chrssi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full)
    );

    // result buffering
    chrssi_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .res_out  (res_out)
    );

    assign report_channel = res_out.report_channel;
    assign peak_rssi      = res_out.peak_rssi;
    assign packet_count   = res_out.packet_count;
    assign active_channel = res_out.active_channel;

endmodule

>>> hw/rtl/chrssi_front.sv
// ----------------------------------------------------------------------------
// chrssi_front
// Accepts requests, classifies the function code and buffers them in a
// short command queue for the back end.
// ----------------------------------------------------------------------------
module chrssi_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [chrssi_pkg::FUNC_W-1:0]     func,
    input  logic signed [chrssi_pkg::RSSI_W-1:0] rssi,
    input  logic [chrssi_pkg::CH_W-1:0]       query_channel,
    output logic                              cmd_valid,
    output chrssi_pkg::cmd_t                  cmd,
    input  logic                              cmd_pop
);
    import chrssi_pkg::*;

    cmd_t            q_mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_CW-1:0] cnt_reg;
    logic [Q_CW-1:0] cnt_next;
    cmd_t            cmd_in;
    logic            do_push;
    logic            do_pop;

    // classify the function code
    always_comb
    begin
        cmd_in.rssi  = rssi;
        cmd_in.query = query_channel;
        unique case (func)
            FUNC_FRAME: cmd_in.op = OP_FRAME;
            FUNC_HOP:   cmd_in.op = OP_HOP;
            FUNC_DECAY: cmd_in.op = OP_DECAY;
            FUNC_CLEAR: cmd_in.op = OP_CLEAR;
            FUNC_READ:  cmd_in.op = OP_READ;
            default:    cmd_in.op = OP_NONE;
        endcase
    end

    // queue status
    assign full      = (cnt_reg == Q_CW'(Q_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CW'(do_push) - Q_CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

>>> hw/rtl/chrssi_resq.sv
// ----------------------------------------------------------------------------
// chrssi_resq
// Short result queue; separates the back end from the result consumer.
// ----------------------------------------------------------------------------
module chrssi_resq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_push,
    input  chrssi_pkg::res_t res_in,
    output logic             res_full,
    input  logic             pop,
    output logic             empty,
    output chrssi_pkg::res_t res_out
);
    import chrssi_pkg::*;

    res_t            q_mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] cnt_reg;
    logic            do_push;
    logic            do_pop;

    // queue status
    assign res_full = (cnt_reg == Q_CW'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign res_out  = q_mem[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            cnt_reg <= cnt_reg + Q_CW'(do_push) - Q_CW'(do_pop);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= res_in;
        end
    end

endmodule

>>> hw/rtl/chrssi_back.sv
// ----------------------------------------------------------------------------
// chrssi_back
// Executes classified requests against the peak and count tables, holds
// the configuration registers and the current channel.
// ----------------------------------------------------------------------------
module chrssi_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [chrssi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [chrssi_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 cmd_valid,
    input  chrssi_pkg::cmd_t                     cmd,
    output logic                                 cmd_pop,
    output logic                                 res_push,
    output chrssi_pkg::res_t                     res,
    input  logic                                 res_full
);
    import chrssi_pkg::*;

    state_t                   state_reg;
    state_t                   state_next;
    cmd_t                     cmd_reg;
    logic [CH_W-1:0]          last_channel_reg;
    logic signed [RSSI_W-1:0] floor_level_reg;
    logic [CH_W-1:0]          cur_reg;
    logic [CH_W-1:0]          hop_reg;
    logic [CH_IDX_W-1:0]      idx_reg;
    logic signed [RSSI_W-1:0] peak_reg  [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]   count_reg [NUM_CHANNELS];
    logic [CH_W-1:0]          lim;
    logic [CH_IDX_W-1:0]      cur_idx;
    logic [CH_IDX_W-1:0]      query_idx;
    logic [CH_IDX_W-1:0]      last_idx;
    logic                     query_ok;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_channel_reg <= RESET_LAST_CHANNEL;
            floor_level_reg  <= RESET_FLOOR;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LAST_CHANNEL: last_channel_reg <= cfg_data[CH_W-1:0];
                REG_FLOOR_LEVEL:  floor_level_reg  <= $signed(cfg_data[RSSI_W-1:0]);
                default:          ;
            endcase
        end
    end

    // effective last channel, clamped to 1..NUM_CHANNELS
    always_comb
    begin
        priority if (last_channel_reg == '0)
        begin
            lim = FIRST_CHANNEL;
        end
        else if (last_channel_reg > CH_W'(NUM_CHANNELS))
        begin
            lim = CH_W'(NUM_CHANNELS);
        end
        else
        begin
            lim = last_channel_reg;
        end
    end

    // table indices
    assign cur_idx   = CH_IDX_W'(cur_reg - FIRST_CHANNEL);
    assign query_idx = CH_IDX_W'(cmd_reg.query - FIRST_CHANNEL);
    assign last_idx  = CH_IDX_W'(lim - FIRST_CHANNEL);
    assign query_ok  = (cmd_reg.query >= FIRST_CHANNEL) && (cmd_reg.query <= lim);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_HOP:   state_next = ST_HOP;
                        OP_DECAY: state_next = ST_SWEEP;
                        default:  state_next = ST_REPORT;
                    endcase
                end
            end
            ST_HOP:
            begin
                if (hop_reg <= lim)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_SWEEP:
            begin
                if (idx_reg == last_idx)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;
        res_push = (state_reg == ST_REPORT) && !res_full;
    end

    // result formation from the tables after the step
    always_comb
    begin
        res.active_channel = cur_reg;
        if (cmd_reg.op == OP_READ)
        begin
            res.report_channel = cmd_reg.query;
            if (query_ok)
            begin
                res.peak_rssi    = peak_reg[query_idx];
                res.packet_count = PKT_W'(count_reg[query_idx]);
            end
            else
            begin
                res.peak_rssi    = OUT_OF_RANGE_PEAK;
                res.packet_count = '0;
            end
        end
        else
        begin
            res.report_channel = cur_reg;
            res.peak_rssi      = peak_reg[cur_idx];
            res.packet_count   = PKT_W'(count_reg[cur_idx]);
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // command latch and working registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
            hop_reg <= cur_reg;
            idx_reg <= '0;
        end
        else if (state_reg == ST_HOP && hop_reg > lim)
        begin
            // repeated subtraction reduces the current channel into 1..last channel
            hop_reg <= hop_reg - lim;
        end
        else if (state_reg == ST_SWEEP)
        begin
            idx_reg <= idx_reg + CH_IDX_W'(1);
        end
    end

    // current channel and channel tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= FIRST_CHANNEL;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                peak_reg[i]  <= RESET_FLOOR;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.op == OP_FRAME)
                        begin
                            if (cmd.rssi > peak_reg[cur_idx])
                            begin
                                peak_reg[cur_idx] <= cmd.rssi;
                            end
                            count_reg[cur_idx] <= count_reg[cur_idx] + COUNT_WIDTH'(1);
                        end
                        else if (cmd.op == OP_CLEAR)
                        begin
                            for (int i = 0; i < NUM_CHANNELS; i++)
                            begin
                                peak_reg[i]  <= floor_level_reg;
                                count_reg[i] <= '0;
                            end
                        end
                    end
                end
                ST_HOP:
                begin
                    if (hop_reg <= lim)
                    begin
                        cur_reg <= (hop_reg == lim) ? FIRST_CHANNEL
                                                    : hop_reg + FIRST_CHANNEL;
                    end
                end
                ST_SWEEP:
                begin
                    // one peak per cycle drops towards the floor
                    if (peak_reg[idx_reg] > floor_level_reg)
                    begin
                        peak_reg[idx_reg] <= peak_reg[idx_reg] - 8'sd1;
                    end
                end
                ST_REPORT: ;
                default:   ;
            endcase
        end
    end

endmodule

>>> hw/rtl/chrssi_checker.sv
// ----------------------------------------------------------------------------
// chrssi_checker
// Port-level checks on the RSSI peak hold monitor, bound to the top level.
// ----------------------------------------------------------------------------
module chrssi_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  empty,
    input  logic                                  pop,
    input  logic [chrssi_pkg::CH_W-1:0]           report_channel,
    input  logic signed [chrssi_pkg::RSSI_W-1:0]  peak_rssi,
    input  logic [chrssi_pkg::PKT_W-1:0]          packet_count,
    input  logic [chrssi_pkg::CH_W-1:0]           active_channel
);
    import chrssi_pkg::*;

    // no result is offered once reset has been seen at an edge
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result offered during reset");

    // the sampled channel always lies in the channel range
    a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (active_channel >= FIRST_CHANNEL)
                && (active_channel <= CH_W'(NUM_CHANNELS)))
        else $error("active channel out of range");

    // a report of a channel outside the table carries the empty values
    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && ((report_channel == '0) || (report_channel > CH_W'(NUM_CHANNELS))))
        |-> (peak_rssi == OUT_OF_RANGE_PEAK) && (packet_count == '0))
        else $error("out of range report with stored values");

    // a waiting result holds until it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(report_channel) && $stable(peak_rssi)
                              && $stable(packet_count) && $stable(active_channel)))
        else $error("waiting result changed");

endmodule

bind channel_rssi_peak_hold_monitor_core chrssi_checker u_chrssi_checker (.*);

>>> tb/tb_channel_rssi_peak_hold_monitor_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_channel_rssi_peak_hold_monitor_core
// Self-checking bench for the per-channel RSSI peak hold monitor. Frame, hop,
// decay, clear, read and unused requests are pushed through the input queue.
// A scoreboard keeps its own channel tables and predicts every report. Most
// phases use a different last channel and floor; the phases cycle through four
// mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_channel_rssi_peak_hold_monitor_core;

    import chrssi_pkg::*;

    // scoreboard: holds its own copy of the channel tables and predicts reports
    class peak_hold_scoreboard;
        logic signed [RSSI_W-1:0] peak_tab [1:NUM_CHANNELS];
        logic [PKT_W-1:0]         count_tab [1:NUM_CHANNELS];
        logic [CH_W-1:0]          cur_ch;
        logic [CH_W-1:0]          last_ch_reg;
        logic signed [RSSI_W-1:0] floor_reg;
        res_t                     expected_reports [$];
        int                       errors;
        int                       reports_checked;

        function new();
            for (int c = 1; c <= NUM_CHANNELS; c++)
            begin
                peak_tab[c]  = RESET_FLOOR;
                count_tab[c] = '0;
            end
            cur_ch          = FIRST_CHANNEL;
            last_ch_reg     = RESET_LAST_CHANNEL;
            floor_reg       = RESET_FLOOR;
            errors          = 0;
            reports_checked = 0;
        endfunction

        // last channel clamped into 1..NUM_CHANNELS
        function int span();
            int l;
            l = int'(last_ch_reg);
            if (l < 1)
                l = 1;
            if (l > NUM_CHANNELS)
                l = NUM_CHANNELS;
            return l;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_LAST_CHANNEL)
                last_ch_reg = data[CH_W-1:0];
            else
                floor_reg = data;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // apply one accepted request to the tables and queue the report it gives
        function void note_request(logic [FUNC_W-1:0] f, logic signed [RSSI_W-1:0] r,
                                   logic [CH_W-1:0] q);
            int   lim;
            res_t rep;
            lim = span();
            if (cur_ch < 1 || cur_ch > NUM_CHANNELS)
                cur_ch = FIRST_CHANNEL;
            case (f)
                FUNC_FRAME:
                begin
                    if (r > peak_tab[cur_ch])
                        peak_tab[cur_ch] = r;
                    count_tab[cur_ch] = count_tab[cur_ch] + 1'b1;
                end
                FUNC_HOP:
                    cur_ch = CH_W'((int'(cur_ch) % lim) + 1);
                FUNC_DECAY:
                    for (int c = 1; c <= lim; c++)
                        if (peak_tab[c] > floor_reg)
                            peak_tab[c] = peak_tab[c] - 8'sd1;
                FUNC_CLEAR:
                    for (int c = 1; c <= NUM_CHANNELS; c++)
                    begin
                        peak_tab[c]  = floor_reg;
                        count_tab[c] = '0;
                    end
                default: ;
            endcase
            if (f == FUNC_READ)
            begin
                rep.report_channel = q;
                if (q >= 1 && int'(q) <= lim)
                begin
                    rep.peak_rssi    = peak_tab[q];
                    rep.packet_count = count_tab[q];
                end
                else
                begin
                    rep.peak_rssi    = OUT_OF_RANGE_PEAK;
                    rep.packet_count = '0;
                end
            end
            else
            begin
                rep.report_channel = cur_ch;
                rep.peak_rssi      = peak_tab[cur_ch];
                rep.packet_count   = count_tab[cur_ch];
            end
            rep.active_channel = cur_ch;
            expected_reports.push_back(rep);
        endfunction

        // compare one popped report with the oldest prediction
        function void check_report(res_t got);
            res_t exp;
            if (expected_reports.size() == 0)
            begin
                $error("report popped with none predicted: channel %0d peak %0d count %0d",
                       got.report_channel, got.peak_rssi, got.packet_count);
                errors++;
                return;
            end
            exp = expected_reports.pop_front();
            reports_checked++;
            if (got.report_channel !== exp.report_channel)
            begin
                $error("report_channel: expected %0d, got %0d",
                       exp.report_channel, got.report_channel);
                errors++;
            end
            if (got.peak_rssi !== exp.peak_rssi)
            begin
                $error("peak_rssi: expected %0d, got %0d", exp.peak_rssi, got.peak_rssi);
                errors++;
            end
            if (got.packet_count !== exp.packet_count)
            begin
                $error("packet_count: expected %0d, got %0d",
                       exp.packet_count, got.packet_count);
                errors++;
            end
            if (got.active_channel !== exp.active_channel)
            begin
                $error("active_channel: expected %0d, got %0d",
                       exp.active_channel, got.active_channel);
                errors++;
            end
        endfunction
    endclass

    // clock, reset and block signals
    logic                        clk   = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        push  = 1'b0;
    logic                        full;
    logic [FUNC_W-1:0]           func          = '0;
    logic signed [RSSI_W-1:0]    rssi          = '0;
    logic [CH_W-1:0]             query_channel = '0;
    logic                        empty;
    logic                        pop   = 1'b0;
    logic [CH_W-1:0]             report_channel;
    logic signed [RSSI_W-1:0]    peak_rssi;
    logic [PKT_W-1:0]            packet_count;
    logic [CH_W-1:0]             active_channel;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data  = '0;

    peak_hold_scoreboard         sb;
    int                          send_idle_pct  = 0;
    int                          recv_stall_pct = 0;
    logic signed [RSSI_W-1:0]    floor_now      = RESET_FLOOR;
    int                          func_seen [8];
    int                          pauses_done    = 0;

    always #10 clk = ~clk;

    channel_rssi_peak_hold_monitor_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .func           (func),
        .rssi           (rssi),
        .query_channel  (query_channel),
        .empty          (empty),
        .pop            (pop),
        .report_channel (report_channel),
        .peak_rssi      (peak_rssi),
        .packet_count   (packet_count),
        .active_channel (active_channel),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // report side: check each popped report, stall pop at random
    always @(posedge clk)
    begin
        if (pop && !empty)
            sb.check_report('{report_channel, peak_rssi, packet_count, active_channel});
        pop <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // push one request, with optional idle cycles ahead of it
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic signed [RSSI_W-1:0] r,
                                input logic [CH_W-1:0] q);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push          <= 1'b1;
        func          <= f;
        rssi          <= r;
        query_channel <= q;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_request(f, r, q);
        func_seen[f]++;
    endtask

    // hold the sender until every predicted report has been popped
    task automatic drain_reports();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(idx, data);
        if (idx == REG_FLOOR_LEVEL)
            floor_now = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // random requests, mostly frames, hops and reads; pause_at < 0 means no pause
    task automatic run_random(input int n, input int pause_at);
        int                       pick;
        logic [FUNC_W-1:0]        f;
        logic signed [RSSI_W-1:0] r;
        logic [CH_W-1:0]          q;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                f = FUNC_FRAME;
            else if (pick < 56)
                f = FUNC_HOP;
            else if (pick < 68)
                f = FUNC_DECAY;
            else if (pick < 71)
                f = FUNC_CLEAR;
            else if (pick < 93)
                f = FUNC_READ;
            else
                f = FUNC_W'($urandom_range(5, 7));
            // half full range, half close to the floor where peaks sit
            if ($urandom_range(0, 1))
                r = RSSI_W'($urandom);
            else
                r = floor_now + RSSI_W'($urandom_range(0, 8)) - 8'sd4;
            q = CH_W'($urandom);
            send_request(f, r, q);
            if (i == pause_at)
            begin
                drain_reports();
                pauses_done++;
            end
        end
    endtask

    // short directed opening at the reset settings
    task automatic run_directed();
        send_request(FUNC_READ, 8'sd0, 4'd0);
        send_request(FUNC_READ, 8'sd0, 4'd15);
        send_request(FUNC_READ, 8'sd0, 4'd14);
        send_request(FUNC_READ, 8'sd0, 4'd13);
        send_request(FUNC_FRAME, 8'sd127, 4'd0);
        send_request(FUNC_FRAME, -8'sd128, 4'd0);
        send_request(FUNC_READ, 8'sd0, 4'd1);
        send_request(FUNC_HOP, 8'sd0, 4'd0);
        send_request(FUNC_FRAME, -8'sd100, 4'd0);
        send_request(FUNC_FRAME, -8'sd99, 4'd0);
        send_request(FUNC_DECAY, 8'sd0, 4'd0);
        send_request(FUNC_DECAY, 8'sd0, 4'd0);
        send_request(3'd5, 8'sd0, 4'd2);
        send_request(3'd6, -8'sd1, 4'd9);
        send_request(3'd7, 8'sd85, 4'd7);
        send_request(FUNC_HOP, 8'sd0, 4'd0);
        send_request(FUNC_READ, 8'sd0, 4'd1);
        send_request(FUNC_CLEAR, 8'sd0, 4'd0);
        send_request(FUNC_READ, 8'sd0, 4'd1);
        send_request(FUNC_DECAY, 8'sd0, 4'd0);
        send_request(FUNC_FRAME, 8'sd0, 4'd0);
        send_request(FUNC_READ, 8'sd0, 4'd3);
    endtask

    // run limit, far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // stimulus phases
    initial
    begin
        logic [CH_W-1:0]       last_sel [8];
        logic [CFG_DATA_W-1:0] floor_sel [8];
        int                    mode;

        sb = new();
        last_sel  = '{4'd13, 4'd14, 4'd1, 4'd0, 4'd15, 4'd3, 4'd13, 4'd13};
        floor_sel = '{8'h9C, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'hC4, 8'h9C, 8'h9C};
        last_sel[6]  = CH_W'($urandom);
        floor_sel[6] = CFG_DATA_W'($urandom);
        foreach (func_seen[k])
            func_seen[k] = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 8; p++)
        begin
            // settings change only once the block has gone quiet
            if (p > 0)
            begin
                drain_reports();
                repeat (20) @(posedge clk);
                write_register(REG_LAST_CHANNEL, CFG_DATA_W'(last_sel[p]));
                write_register(REG_FLOOR_LEVEL, floor_sel[p]);
            end
            mode = p % 4;
            send_idle_pct  = (mode == 1) ? 51 : (mode == 3) ? 34 : 0;
            recv_stall_pct = (mode == 2) ? 51 : (mode == 3) ? 34 : 0;
            if (p == 0)
                run_directed();
            run_random(150, (p == 4) ? 75 : -1);
        end
        push <= 1'b0;

        // wait for the last reports, bounded
        for (int w = 0; w < 100000 && sb.pending() != 0; w++)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d predicted reports never popped", sb.pending());
            sb.errors++;
        end

        $display("covered: %0d frames, %0d hops, %0d decays, %0d clears, %0d reads, %0d unused codes",
                 func_seen[FUNC_FRAME], func_seen[FUNC_HOP], func_seen[FUNC_DECAY],
                 func_seen[FUNC_CLEAR], func_seen[FUNC_READ],
                 func_seen[5] + func_seen[6] + func_seen[7]);
        $display("8 settings phases, %0d reports checked, %0d sender drains, %0d mismatches",
                 sb.reports_checked, pauses_done, sb.errors);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
